@@ hdl/utf8sv_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8sv_pkg
// Shared types, constants and the code point check for the UTF-8 validator.
// ----------------------------------------------------------------------------
package utf8sv_pkg;

  localparam int unsigned CountW = 18;
  localparam int unsigned CodeW  = 21;

  localparam logic [CountW-1:0] CountCap     = 18'h3FFFF;
  localparam logic [CountW-1:0] MaxLenReset  = 18'd131072;

  localparam logic [7:0] LeadTwoLo   = 8'hC2;
  localparam logic [7:0] LeadTwoHi   = 8'hDF;
  localparam logic [7:0] LeadThreeLo = 8'hE0;
  localparam logic [7:0] LeadThreeHi = 8'hEF;
  localparam logic [7:0] LeadFourLo  = 8'hF0;
  localparam logic [7:0] LeadFourHi  = 8'hF4;
  localparam logic [7:0] AsciiTop    = 8'h80;

  localparam logic [CodeW-1:0] CodeMax     = 21'h10FFFF;
  localparam logic [CodeW-1:0] SurrLo      = 21'h00D800;
  localparam logic [CodeW-1:0] SurrHi      = 21'h00DFFF;
  localparam logic [CodeW-1:0] MinTwo      = 21'h000080;
  localparam logic [CodeW-1:0] MinThree    = 21'h000800;
  localparam logic [CodeW-1:0] MinFour     = 21'h010000;
  localparam logic [15:0]      NonCharLo   = 16'hFFFE;
  localparam logic [CodeW-1:0] CtrlTop     = 21'h000020;
  localparam logic [CodeW-1:0] CpTab       = 21'h000009;
  localparam logic [CodeW-1:0] CpLf        = 21'h00000A;
  localparam logic [CodeW-1:0] CpCr        = 21'h00000D;

  localparam logic [2:0] SizeOne   = 3'd1;
  localparam logic [2:0] SizeTwo   = 3'd2;
  localparam logic [2:0] SizeThree = 3'd3;
  localparam logic [2:0] SizeFour  = 3'd4;

  typedef struct packed {
    logic [1:0]        pending;
    logic [CodeW-1:0]  code;
    logic [2:0]        size;
    logic              fault;
    logic [CountW-1:0] count;
  } body_state_t;

  function automatic logic code_ok(input logic [CodeW-1:0] cp, input logic [2:0] size);
    logic ok;
    ok = 1'b1;
    if (size == SizeTwo && cp < MinTwo) ok = 1'b0;
    if (size == SizeThree && cp < MinThree) ok = 1'b0;
    if (size == SizeFour && cp < MinFour) ok = 1'b0;
    if (cp > CodeMax) ok = 1'b0;
    if (cp >= SurrLo && cp <= SurrHi) ok = 1'b0;
    if (cp[15:0] >= NonCharLo) ok = 1'b0;
    if (cp < CtrlTop && cp != CpTab && cp != CpLf && cp != CpCr) ok = 1'b0;
    return ok;
  endfunction

endpackage

@@ hdl/utf8_stream_validator_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_stream_validator_core
// Strict UTF-8 and length check of a byte stream, one verdict per body.
// ----------------------------------------------------------------------------
// Takes one body byte per beat and sustains one beat per clock: the decoder
// and byte counter compute their next body state combinationally, which sets
// the rate. A beat is registered at the input and decoded in the next cycle;
// the verdict for a body is registered when its tlast beat leaves the input
// register, and out_tvalid comes from that verdict register. The input keeps
// taking beats while a verdict waits; it stalls only when a tlast beat meets
// a full output stage.
// ----------------------------------------------------------------------------
module utf8_stream_validator_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [17:0] cfg_data,    // [17:0] max_length
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [7:0] data_byte
  input  logic        in_tlast,    // last_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata    // [0] body_valid, [18:1] body_length, [23:19] zero
);
  import utf8sv_pkg::*;

  logic [CountW-1:0] max_len_r;
  logic              in_v_r;
  logic [7:0]        byte_r;
  logic              last_r;
  body_state_t       st_r, st_nxt;
  logic              out_v_r;
  logic              verdict_r;
  logic [CountW-1:0] length_r;

  logic              out_free;
  logic              adv;
  logic [CountW-1:0] lim;
  logic              verdict_nxt;

  assign cfg_ready  = 1'b1;
  assign out_free   = !out_v_r || out_tready;
  assign adv        = in_v_r && (!last_r || out_free);
  assign in_tready  = !in_v_r || adv;
  assign out_tvalid = out_v_r;
  assign out_tdata  = {5'd0, length_r, verdict_r};

  always_comb begin
    st_nxt = st_r;
    lim    = (max_len_r == CountCap) ? CountCap : max_len_r + 18'd1;
    if (st_r.count == CountCap) st_nxt.fault = 1'b1;
    if (st_r.count < lim) st_nxt.count = st_r.count + 18'd1;
    if (!st_nxt.fault) begin
      if (st_r.pending == 2'd0) begin
        if (byte_r < AsciiTop) begin
          st_nxt.size = SizeOne;
          if (!code_ok({13'd0, byte_r}, SizeOne)) st_nxt.fault = 1'b1;
        end else if (byte_r >= LeadTwoLo && byte_r <= LeadTwoHi) begin
          st_nxt.code    = {16'd0, byte_r[4:0]};
          st_nxt.pending = 2'd1;
          st_nxt.size    = SizeTwo;
        end else if (byte_r >= LeadThreeLo && byte_r <= LeadThreeHi) begin
          st_nxt.code    = {17'd0, byte_r[3:0]};
          st_nxt.pending = 2'd2;
          st_nxt.size    = SizeThree;
        end else if (byte_r >= LeadFourLo && byte_r <= LeadFourHi) begin
          st_nxt.code    = {18'd0, byte_r[2:0]};
          st_nxt.pending = 2'd3;
          st_nxt.size    = SizeFour;
        end else begin
          st_nxt.fault = 1'b1;
        end
      end else if (byte_r[7:6] != 2'b10) begin
        st_nxt.fault = 1'b1;
      end else begin
        st_nxt.code    = {st_r.code[14:0], byte_r[5:0]};
        st_nxt.pending = st_r.pending - 2'd1;
        if (st_nxt.pending == 2'd0 && !code_ok(st_nxt.code, st_r.size)) begin
          st_nxt.fault = 1'b1;
        end
      end
    end
    verdict_nxt = !st_nxt.fault && st_nxt.pending == 2'd0 && st_nxt.count <= max_len_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= MaxLenReset;
    end else if (cfg_valid && cfg_ready) begin
      max_len_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_tready) begin
      in_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      byte_r <= in_tdata;
      last_r <= in_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.pending <= 2'd0;
      st_r.code    <= '0;
      st_r.size    <= SizeOne;
      st_r.fault   <= 1'b0;
      st_r.count   <= '0;
    end else if (adv) begin
      if (last_r) begin
        st_r.pending <= 2'd0;
        st_r.code    <= '0;
        st_r.size    <= SizeOne;
        st_r.fault   <= 1'b0;
        st_r.count   <= '0;
      end else begin
        st_r <= st_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv && last_r) begin
      out_v_r <= 1'b1;
    end else if (out_tready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && last_r) begin
      verdict_r <= verdict_nxt;
      length_r  <= st_nxt.count;
    end
  end

  // open sequence always owes fewer bytes than its length
  a_pending_size: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.pending != 2'd0 |-> st_r.size > {1'b0, st_r.pending})
    else $error("pending count exceeds sequence size");

  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    adv && last_r |=> st_r.count == '0 && !st_r.fault && st_r.pending == 2'd0)
    else $error("body state not cleared after final beat");

  a_verdict_shown: assert property (@(posedge clk) disable iff (!rst_n)
    adv && last_r |=> out_v_r)
    else $error("final beat produced no verdict");

  a_length_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> length_r != '0)
    else $error("verdict with zero length");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && !out_tready |=> $stable(length_r) && $stable(verdict_r))
    else $error("pending verdict overwritten");

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the UTF-8 stream validator against a cycle-free verdict predictor.
// Bodies of directed and random byte sequences (legal characters, overlong
// forms, surrogates, noncharacters, controls, bad leads, broken and truncated
// sequences, raw noise) are streamed under several length limits, including
// zero and one. The sender idles in bursts and the receiver stalls on its own
// pattern. Every verdict beat is compared with the predicted one.
// ----------------------------------------------------------------------------
module testbench;
  import utf8sv_pkg::*;

  typedef struct packed {
    bit              ok;
    bit [CountW-1:0] len;
  } verdict_t;

  typedef enum int {
    CH_GOOD, CH_OVERLONG, CH_SURROGATE, CH_TOO_HIGH, CH_NONCHAR,
    CH_CONTROL, CH_BAD_LEAD, CH_BROKEN_CONT, CH_TRUNCATED
  } char_kind_e;

  typedef enum int {
    READY_ALWAYS, READY_COIN, READY_ONE_IN_FOUR, READY_RARE
  } ready_mode_e;

  class VerdictBoard;
    bit [CountW-1:0] limit;
    bit [1:0]        owed;
    bit [CodeW-1:0]  code;
    bit [2:0]        seq_len;
    bit              faulted;
    bit [CountW-1:0] count;
    verdict_t        verdicts[$];
    int              errors;

    function new();
      limit  = MaxLenReset;
      errors = 0;
      clear_body();
    endfunction

    function void clear_body();
      owed    = 2'd0;
      code    = '0;
      seq_len = SizeOne;
      faulted = 1'b0;
      count   = '0;
    endfunction

    static function bit code_legal(bit [CodeW-1:0] cp, bit [2:0] size);
      bit [CodeW-1:0] floor_cp;
      case (size)
        SizeTwo:   floor_cp = MinTwo;
        SizeThree: floor_cp = MinThree;
        SizeFour:  floor_cp = MinFour;
        default:   floor_cp = '0;
      endcase
      if (cp < floor_cp || cp > CodeMax) return 1'b0;
      if (cp >= SurrLo && cp <= SurrHi) return 1'b0;
      if (cp[15:0] >= NonCharLo) return 1'b0;
      if (cp < CtrlTop) return (cp == CpTab || cp == CpLf || cp == CpCr);
      return 1'b1;
    endfunction

    function void decode_byte(bit [7:0] b);
      if (owed == 2'd0) begin
        if (b < AsciiTop) begin
          seq_len = SizeOne;
          if (!code_legal({13'd0, b}, SizeOne)) faulted = 1'b1;
        end else if (b >= LeadTwoLo && b <= LeadTwoHi) begin
          code = {16'd0, b[4:0]}; owed = 2'd1; seq_len = SizeTwo;
        end else if (b >= LeadThreeLo && b <= LeadThreeHi) begin
          code = {17'd0, b[3:0]}; owed = 2'd2; seq_len = SizeThree;
        end else if (b >= LeadFourLo && b <= LeadFourHi) begin
          code = {18'd0, b[2:0]}; owed = 2'd3; seq_len = SizeFour;
        end else begin
          faulted = 1'b1;
        end
      end else if (b[7:6] != 2'b10) begin
        faulted = 1'b1;
      end else begin
        code = {code[CodeW-7:0], b[5:0]};
        owed = owed - 2'd1;
        if (owed == 2'd0 && !code_legal(code, seq_len)) faulted = 1'b1;
      end
    endfunction

    function void note_beat(bit [7:0] b, bit last);
      bit [CountW:0] ceiling;
      verdict_t v;
      ceiling = {1'b0, limit} + 1'b1;
      if (ceiling > {1'b0, CountCap}) ceiling = {1'b0, CountCap};
      if (count == CountCap) faulted = 1'b1;
      if ({1'b0, count} < ceiling) count = count + 1'b1;
      if (!faulted) decode_byte(b);
      if (last) begin
        v.ok  = !faulted && owed == 2'd0 && count <= limit;
        v.len = count;
        verdicts.push_back(v);
        clear_body();
      end
    endfunction

    function void check_verdict(logic [23:0] word);
      verdict_t want;
      if (verdicts.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected verdict beat: valid=%0d length=%0d", word[0], word[18:1]);
        return;
      end
      want = verdicts.pop_front();
      if (word[0] !== want.ok || word[18:1] !== want.len) begin
        errors++;
        if (errors <= 10)
          $display("verdict mismatch: expected valid=%0d length=%0d, got valid=%0d length=%0d",
                   want.ok, want.len, word[0], word[18:1]);
      end
    endfunction

    function int outstanding();
      return verdicts.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [17:0] cfg_data;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;    // [7:0] data_byte
  logic        in_tlast;    // last_byte
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;   // [0] body_valid, [18:1] body_length, [23:19] zero

  VerdictBoard sb = new();
  bit [7:0]    body_q[$];
  int          burst_left;
  bit          gaps_on;
  int          random_beats;
  ready_mode_e ready_mode;
  int          ready_span;
  int          ready_tick;

  utf8_stream_validator_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    #8_000_000;
    $display("[utf8_stream_validator_core] ERROR");
    $finish;
  end

  // receiver stall pattern
  always @(negedge clk) begin
    if (ready_span == 0) begin
      ready_mode = ready_mode_e'($urandom_range(0, 3));
      ready_span = $urandom_range(20, 200);
    end
    ready_span--;
    ready_tick++;
    case (ready_mode)
      READY_ALWAYS:      out_tready <= 1'b1;
      READY_COIN:        out_tready <= $urandom_range(0, 1);
      READY_ONE_IN_FOUR: out_tready <= (ready_tick % 4 == 0);
      default:           out_tready <= ($urandom_range(0, 15) == 0);
    endcase
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) sb.limit = cfg_data;
      if (in_tvalid && in_tready) sb.note_beat(in_tdata, in_tlast);
      if (out_tvalid && out_tready) sb.check_verdict(out_tdata);
    end
  end

  task automatic send_beat(input bit [7:0] b, input bit last);
    int gap;
    if (gaps_on && burst_left == 0) begin
      gap = $urandom_range(1, 6);
      repeat (gap) begin
        @(negedge clk);
        in_tvalid <= 1'b0;
      end
      burst_left = $urandom_range(1, 16);
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (burst_left > 0) burst_left--;
  endtask

  task automatic send_body();
    for (int i = 0; i < body_q.size(); i++) send_beat(body_q[i], i == body_q.size() - 1);
  endtask

  // up to four bytes in the low bytes of the word, first byte the most significant
  task automatic send_short(input bit [31:0] bytes, input int n);
    body_q.delete();
    for (int i = n - 1; i >= 0; i--) body_q.push_back(bytes[8*i +: 8]);
    send_body();
  endtask

  task automatic send_run(input int len);
    for (int i = 0; i < len; i++) send_beat(8'h78, i == len - 1);
  endtask

  task automatic settle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_limit(input bit [17:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic push_as(input bit [CodeW-1:0] cp, input int size);
    case (size)
      1: body_q.push_back(cp[7:0]);
      2: begin
        body_q.push_back({3'b110, cp[10:6]});
        body_q.push_back({2'b10, cp[5:0]});
      end
      3: begin
        body_q.push_back({4'b1110, cp[15:12]});
        body_q.push_back({2'b10, cp[11:6]});
        body_q.push_back({2'b10, cp[5:0]});
      end
      default: begin
        body_q.push_back({5'b11110, cp[20:18]});
        body_q.push_back({2'b10, cp[17:12]});
        body_q.push_back({2'b10, cp[11:6]});
        body_q.push_back({2'b10, cp[5:0]});
      end
    endcase
  endtask

  function automatic bit [CodeW-1:0] legal_cp(input int size);
    bit [CodeW-1:0] cp;
    do begin
      case (size)
        1:       cp = $urandom_range(0, 'h7F);
        2:       cp = $urandom_range('h80, 'h7FF);
        3:       cp = $urandom_range('h800, 'hFFFF);
        default: cp = $urandom_range('h10000, 'h10FFFF);
      endcase
    end while (!VerdictBoard::code_legal(cp, size));
    return cp;
  endfunction

  task automatic push_char(input char_kind_e kind);
    int             s;
    int             pos;
    int             plane;
    bit [7:0]       b;
    bit [CodeW-1:0] cp;
    case (kind)
      CH_GOOD: begin
        s = $urandom_range(1, 4);
        push_as(legal_cp(s), s);
      end
      CH_OVERLONG: begin
        s = $urandom_range(2, 4);
        cp = $urandom_range(0, s == 2 ? 'h7F : (s == 3 ? 'h7FF : 'hFFFF));
        push_as(cp, s);
      end
      CH_SURROGATE: push_as(SurrLo + $urandom_range(0, 'h7FF), 3);
      CH_TOO_HIGH:  push_as($urandom_range('h110000, 'h1FFFFF), 4);
      CH_NONCHAR: begin
        plane = $urandom_range(0, 16);
        cp = (plane << 16) | NonCharLo | $urandom_range(0, 1);
        push_as(cp, plane == 0 ? 3 : 4);
      end
      CH_CONTROL: begin
        do cp = $urandom_range(0, 31); while (VerdictBoard::code_legal(cp, SizeOne));
        push_as(cp, 1);
      end
      CH_BAD_LEAD: begin
        do b = $urandom_range('h80, 'hFF); while (b >= LeadTwoLo && b <= LeadFourHi);
        body_q.push_back(b);
      end
      CH_BROKEN_CONT: begin
        s = $urandom_range(2, 4);
        push_as(legal_cp(s), s);
        pos = body_q.size() - $urandom_range(1, s - 1);
        b = $urandom_range(0, 191);
        if (b >= 8'h80) b = b + 8'h40;
        body_q[pos] = b;
      end
      default: begin
        s = $urandom_range(2, 4);
        push_as(legal_cp(s), s);
        repeat ($urandom_range(1, s - 1)) void'(body_q.pop_back());
      end
    endcase
  endtask

  task automatic make_body();
    int n;
    body_q.delete();
    if ($urandom_range(0, 9) == 0) begin
      n = $urandom_range(1, 12);
      repeat (n) body_q.push_back($urandom_range(0, 255));
    end else begin
      n = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 8);
      repeat (n) begin
        if ($urandom_range(0, 99) < 90) push_char(CH_GOOD);
        else push_char(char_kind_e'($urandom_range(CH_OVERLONG, CH_TRUNCATED)));
      end
    end
  endtask

  function automatic bit [17:0] pick_limit(input int phase);
    if (phase == 0) return MaxLenReset;
    if (phase == 1) return 18'd1;
    case ($urandom_range(0, 4))
      0:       return $urandom_range(1, 8);
      1:       return $urandom_range(9, 40);
      2:       return $urandom_range(41, 131072);
      3:       return MaxLenReset;
      default: return $urandom_range(2, 3);
    endcase
  endfunction

  initial begin
    int phase;
    int phase_beats;
    rst_n      = 1'b0;
    cfg_valid  = 1'b0;
    cfg_data   = '0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tlast   = 1'b0;
    burst_left = 0;
    gaps_on    = 1'b1;
    random_beats = 0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // directed bodies under the reset limit
    send_short(32'h410A, 2);
    send_short(32'h090A0D, 3);
    send_short(32'h00, 1);
    send_short(32'h7F, 1);
    send_short(32'hC280, 2);
    send_short(32'hDFBF, 2);
    send_short(32'hE0A080, 3);
    send_short(32'hEFBFBD, 3);
    send_short(32'hF0908080, 4);
    send_short(32'hF48FBFBD, 4);
    send_short(32'hC080, 2);
    send_short(32'hE09FBF, 3);
    send_short(32'hF08FBFBF, 4);
    send_short(32'hEDA080, 3);
    send_short(32'hF4908080, 4);
    send_short(32'hEFBFBE, 3);
    send_short(32'hF0BFBFBF, 4);
    send_short(32'hF5, 1);
    send_short(32'h80, 1);
    send_short(32'hE282, 2);
    send_short(32'hC341, 2);
    send_short(32'hFF4142, 3);
    settle();
    write_limit(18'd1);
    send_short(32'h61, 1);
    send_short(32'h6162, 2);
    settle();
    write_limit(18'd0);
    send_short(32'h61, 1);
    send_short(32'h616263, 3);
    settle();

    phase = 0;
    while (random_beats < 1450) begin
      write_limit(pick_limit(phase));
      gaps_on = ($urandom_range(0, 3) != 0);
      phase_beats = 0;
      while (phase_beats < 120) begin
        make_body();
        send_body();
        phase_beats += body_q.size();
      end
      random_beats += phase_beats;
      settle();
      phase++;
    end

    // plain runs just over and exactly at a small limit
    gaps_on = 1'b0;
    write_limit(18'd40);
    send_run(41);
    send_run(40);
    settle();
    repeat (8) @(posedge clk);

    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("[utf8_stream_validator_core] OK");
    end else begin
      $display("[utf8_stream_validator_core] ERROR");
    end
    $finish;
  end

endmodule
